// File: hw/rtl/crc16_rx_pkg.sv
package crc16_rx_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned APB_W   = 32;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_BAD_CRC = 2'd2
    } t_status;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_HDR_FIRST  = 2'd0,
        REG_HDR_SECOND = 2'd1,
        REG_XOR_KEY    = 2'd2,
        REG_MAX_LEN    = 2'd3
    } t_reg_idx;

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crc16_modbus_frame_receiver_core.sv
// Frame receiver for CRC-16/MODBUS framed packets.
// Input channel: one received byte per beat on i_byte_in (i_in_valid / o_in_ready).
// Output channel: one result per beat (o_out_valid / i_out_ready). A data result
// (o_kind 0) carries a payload byte XORed with the key and its index in the frame.
// An end result (o_kind 1) carries the frame status and the received length field.
// Only a CRC check or a zero or over-limit length field produces an end result.
// A byte sits in the input register and is decoded into the output
// register when it advances; a waiting result can stall it there.
// One byte is taken every cycle unless a waiting result stalls it; the rate is
// set by the combinational CRC fold and phase decode between the registers.
// When the receiver holds i_out_ready low with a result pending, the input
// register takes beats until one yields a result; o_in_ready then drops until
// the result is taken. Bytes that produce no result keep flowing meanwhile.
// The user must write configuration over the APB port only while no traffic
// is in flight; the block does not enforce it. Reset clears both valid flags,
// returns to header hunting with CRC 0xFFFF, resets registers (max len 1024).
module crc16_modbus_frame_receiver_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [crc16_rx_pkg::BYTE_W-1:0]       i_byte_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_kind,
    output logic [crc16_rx_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [crc16_rx_pkg::LEN_W-1:0]        o_byte_index,
    output logic [crc16_rx_pkg::STAT_W-1:0]       o_status,
    output logic [crc16_rx_pkg::LEN_W-1:0]        o_payload_length,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crc16_rx_pkg::ADDR_W-1:0]       paddr,
    input  logic [crc16_rx_pkg::APB_W-1:0]        pwdata,
    output logic [crc16_rx_pkg::APB_W-1:0]        prdata,
    output logic                                  pready
);

    logic [crc16_rx_pkg::BYTE_W-1:0] r_hdr_first;
    logic [crc16_rx_pkg::BYTE_W-1:0] r_hdr_second;
    logic [crc16_rx_pkg::BYTE_W-1:0] r_xor_key;
    logic [crc16_rx_pkg::LEN_W-1:0]  r_max_len;

    logic                            r_in_valid;
    logic [crc16_rx_pkg::BYTE_W-1:0] r_in_byte;

    crc16_rx_pkg::t_phase            r_phase, n_phase;
    logic [crc16_rx_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [crc16_rx_pkg::LEN_W-1:0]  r_len, n_len;
    logic [crc16_rx_pkg::LEN_W-1:0]  r_seen, n_seen;
    logic [crc16_rx_pkg::BYTE_W-1:0] r_crc_lo, n_crc_lo;

    logic                            r_out_valid;
    logic                            r_kind, n_kind;
    logic [crc16_rx_pkg::BYTE_W-1:0] r_data, n_data;
    logic [crc16_rx_pkg::LEN_W-1:0]  r_idx, n_idx;
    logic [crc16_rx_pkg::STAT_W-1:0] r_status, n_status;
    logic [crc16_rx_pkg::LEN_W-1:0]  r_plen, n_plen;

    logic                            produce;
    logic                            advance;
    logic [crc16_rx_pkg::LEN_W-1:0]  len_full;
    logic [crc16_rx_pkg::LEN_W-1:0]  seen_next;
    logic [crc16_rx_pkg::CRC_W-1:0]  rx_crc;
    logic                            cfg_wr;
    crc16_rx_pkg::t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = crc16_rx_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            crc16_rx_pkg::REG_HDR_FIRST:  prdata[crc16_rx_pkg::BYTE_W-1:0] = r_hdr_first;
            crc16_rx_pkg::REG_HDR_SECOND: prdata[crc16_rx_pkg::BYTE_W-1:0] = r_hdr_second;
            crc16_rx_pkg::REG_XOR_KEY:    prdata[crc16_rx_pkg::BYTE_W-1:0] = r_xor_key;
            crc16_rx_pkg::REG_MAX_LEN:    prdata[crc16_rx_pkg::LEN_W-1:0]  = r_max_len;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
            r_xor_key    <= '0;
            r_max_len    <= crc16_rx_pkg::MAX_LEN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                crc16_rx_pkg::REG_HDR_FIRST:  r_hdr_first  <= pwdata[crc16_rx_pkg::BYTE_W-1:0];
                crc16_rx_pkg::REG_HDR_SECOND: r_hdr_second <= pwdata[crc16_rx_pkg::BYTE_W-1:0];
                crc16_rx_pkg::REG_XOR_KEY:    r_xor_key    <= pwdata[crc16_rx_pkg::BYTE_W-1:0];
                crc16_rx_pkg::REG_MAX_LEN:    r_max_len    <= pwdata[crc16_rx_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign len_full  = {r_in_byte, r_len[crc16_rx_pkg::BYTE_W-1:0]};
    assign seen_next = r_seen + 1'b1;
    assign rx_crc    = {r_in_byte, r_crc_lo};

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_len    = r_len;
        n_seen   = r_seen;
        n_crc_lo = r_crc_lo;
        produce  = 1'b0;
        n_kind   = crc16_rx_pkg::KIND_DATA;
        n_data   = '0;
        n_idx    = '0;
        n_status = crc16_rx_pkg::ST_GOOD;
        n_plen   = r_len;
        case (r_phase)
            crc16_rx_pkg::PH_HUNT2: begin
                if (r_in_byte == r_hdr_second) begin
                    n_crc   = crc16_rx_pkg::crc_fold(r_crc, r_in_byte);
                    n_phase = crc16_rx_pkg::PH_LEN_LO;
                end else if (r_in_byte == r_hdr_first) begin
                    n_crc = crc16_rx_pkg::crc_fold(crc16_rx_pkg::CRC_INIT, r_in_byte);
                end else begin
                    n_crc   = crc16_rx_pkg::CRC_INIT;
                    n_phase = crc16_rx_pkg::PH_HUNT1;
                end
            end
            crc16_rx_pkg::PH_LEN_LO: begin
                n_crc   = crc16_rx_pkg::crc_fold(r_crc, r_in_byte);
                n_len   = {{(crc16_rx_pkg::LEN_W-crc16_rx_pkg::BYTE_W){1'b0}}, r_in_byte};
                n_phase = crc16_rx_pkg::PH_LEN_HI;
            end
            crc16_rx_pkg::PH_LEN_HI: begin
                n_crc  = crc16_rx_pkg::crc_fold(r_crc, r_in_byte);
                n_len  = len_full;
                n_plen = len_full;
                n_seen = '0;
                if (len_full == '0 || len_full > r_max_len) begin
                    produce  = 1'b1;
                    n_kind   = crc16_rx_pkg::KIND_END;
                    n_status = crc16_rx_pkg::ST_BAD_LEN;
                    n_crc    = crc16_rx_pkg::CRC_INIT;
                    n_phase  = crc16_rx_pkg::PH_HUNT1;
                end else begin
                    n_phase = crc16_rx_pkg::PH_PAYLOAD;
                end
            end
            crc16_rx_pkg::PH_PAYLOAD: begin
                n_crc   = crc16_rx_pkg::crc_fold(r_crc, r_in_byte);
                produce = 1'b1;
                n_data  = r_in_byte ^ r_xor_key;
                n_idx   = r_seen;
                n_seen  = seen_next;
                if (seen_next >= r_len) begin
                    n_phase = crc16_rx_pkg::PH_CRC_LO;
                end
            end
            crc16_rx_pkg::PH_CRC_LO: begin
                n_crc_lo = r_in_byte;
                n_phase  = crc16_rx_pkg::PH_CRC_HI;
            end
            crc16_rx_pkg::PH_CRC_HI: begin
                produce  = 1'b1;
                n_kind   = crc16_rx_pkg::KIND_END;
                n_status = (rx_crc == r_crc) ? crc16_rx_pkg::ST_GOOD
                                             : crc16_rx_pkg::ST_BAD_CRC;
                n_crc    = crc16_rx_pkg::CRC_INIT;
                n_phase  = crc16_rx_pkg::PH_HUNT1;
            end
            default: begin
                if (r_in_byte == r_hdr_first) begin
                    n_crc   = crc16_rx_pkg::crc_fold(crc16_rx_pkg::CRC_INIT, r_in_byte);
                    n_phase = crc16_rx_pkg::PH_HUNT2;
                end else begin
                    n_crc   = crc16_rx_pkg::CRC_INIT;
                    n_phase = crc16_rx_pkg::PH_HUNT1;
                end
            end
        endcase
    end

    assign advance    = r_in_valid && (!produce || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= crc16_rx_pkg::PH_HUNT1;
            r_crc    <= crc16_rx_pkg::CRC_INIT;
            r_len    <= '0;
            r_seen   <= '0;
            r_crc_lo <= '0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_idx    <= n_idx;
            r_status <= n_status;
            r_plen   <= n_plen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_byte_index     = r_idx;
    assign o_status         = r_status;
    assign o_payload_length = r_plen;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  status;
    logic [15:0] payload_length;
} t_frame_result;

function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? crc16_rx_pkg::CRC_POLY : 16'h0000);
    return r;
endfunction

class t_frame_scoreboard;
    logic [7:0]            hdr_first;
    logic [7:0]            hdr_second;
    logic [7:0]            key;
    logic [15:0]           len_limit;
    crc16_rx_pkg::t_phase  phase;
    logic [15:0]           crc;
    logic [15:0]           len_field;
    logic [15:0]           seen;
    logic [7:0]            crc_lo;
    t_frame_result         expected_q[$];
    int                    errors;
    int                    payload_beats;
    int                    ends_by_status[3];

    function new();
        hdr_first  = 8'h00;
        hdr_second = 8'h00;
        key        = 8'h00;
        len_limit  = crc16_rx_pkg::MAX_LEN_RESET;
        phase      = crc16_rx_pkg::PH_HUNT1;
        crc        = crc16_rx_pkg::CRC_INIT;
        len_field  = 16'h0000;
        seen       = 16'h0000;
        crc_lo     = 8'h00;
        errors     = 0;
    endfunction

    function void set_reg(crc16_rx_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            crc16_rx_pkg::REG_HDR_FIRST: hdr_first = value[7:0];
            crc16_rx_pkg::REG_HDR_SECOND: hdr_second = value[7:0];
            crc16_rx_pkg::REG_XOR_KEY: key = value[7:0];
            crc16_rx_pkg::REG_MAX_LEN: len_limit = value[15:0];
            default: ;
        endcase
    endfunction

    function void push_result(crc16_rx_pkg::t_kind kind, logic [7:0] data, logic [15:0] idx,
                              crc16_rx_pkg::t_status st);
        t_frame_result r;
        r.kind           = kind;
        r.data_byte      = data;
        r.byte_index     = idx;
        r.status         = st;
        r.payload_length = len_field;
        expected_q.push_back(r);
    endfunction

    function void restart_hunt();
        phase = crc16_rx_pkg::PH_HUNT1;
        crc   = crc16_rx_pkg::CRC_INIT;
    endfunction

    function void note_byte(logic [7:0] b);
        case (phase)
            crc16_rx_pkg::PH_HUNT2: begin
                if (b == hdr_second) begin
                    crc   = modbus_crc_step(crc, b);
                    phase = crc16_rx_pkg::PH_LEN_LO;
                end else if (b == hdr_first) begin
                    crc = modbus_crc_step(crc16_rx_pkg::CRC_INIT, b);
                end else begin
                    restart_hunt();
                end
            end
            crc16_rx_pkg::PH_LEN_LO: begin
                crc       = modbus_crc_step(crc, b);
                len_field = {8'h00, b};
                phase     = crc16_rx_pkg::PH_LEN_HI;
            end
            crc16_rx_pkg::PH_LEN_HI: begin
                crc             = modbus_crc_step(crc, b);
                len_field[15:8] = b;
                seen            = 16'h0000;
                if (len_field == 16'h0000 || len_field > len_limit) begin
                    push_result(crc16_rx_pkg::KIND_END, 8'h00, 16'h0000,
                                crc16_rx_pkg::ST_BAD_LEN);
                    restart_hunt();
                end else begin
                    phase = crc16_rx_pkg::PH_PAYLOAD;
                end
            end
            crc16_rx_pkg::PH_PAYLOAD: begin
                crc = modbus_crc_step(crc, b);
                push_result(crc16_rx_pkg::KIND_DATA, b ^ key, seen, crc16_rx_pkg::ST_GOOD);
                seen = seen + 16'h0001;
                if (seen >= len_field) begin
                    phase = crc16_rx_pkg::PH_CRC_LO;
                end
            end
            crc16_rx_pkg::PH_CRC_LO: begin
                crc_lo = b;
                phase  = crc16_rx_pkg::PH_CRC_HI;
            end
            crc16_rx_pkg::PH_CRC_HI: begin
                push_result(crc16_rx_pkg::KIND_END, 8'h00, 16'h0000,
                            ({b, crc_lo} == crc) ? crc16_rx_pkg::ST_GOOD
                                                 : crc16_rx_pkg::ST_BAD_CRC);
                restart_hunt();
            end
            default: begin
                if (b == hdr_first) begin
                    crc   = modbus_crc_step(crc16_rx_pkg::CRC_INIT, b);
                    phase = crc16_rx_pkg::PH_HUNT2;
                end else begin
                    restart_hunt();
                end
            end
        endcase
    endfunction

    function void report_field(string field, logic [15:0] want, logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_result(t_frame_result got);
        t_frame_result want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                     $time, got.kind, got.status);
            return;
        end
        want = expected_q.pop_front();
        if (got.kind !== want.kind) begin
            report_field("kind", 16'(want.kind), 16'(got.kind));
        end
        if (got.data_byte !== want.data_byte) begin
            report_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        end
        if (got.byte_index !== want.byte_index) begin
            report_field("byte_index", want.byte_index, got.byte_index);
        end
        if (got.status !== want.status) begin
            report_field("status", 16'(want.status), 16'(got.status));
        end
        if (got.payload_length !== want.payload_length) begin
            report_field("payload_length", want.payload_length, got.payload_length);
        end
        if (want.kind == crc16_rx_pkg::KIND_DATA) begin
            payload_beats++;
        end else begin
            ends_by_status[want.status]++;
        end
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 2000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [crc16_rx_pkg::BYTE_W-1:0]   i_byte_in;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_kind;
    logic [crc16_rx_pkg::BYTE_W-1:0]   o_data_byte;
    logic [crc16_rx_pkg::LEN_W-1:0]    o_byte_index;
    logic [crc16_rx_pkg::STAT_W-1:0]   o_status;
    logic [crc16_rx_pkg::LEN_W-1:0]    o_payload_length;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [crc16_rx_pkg::ADDR_W-1:0]   paddr;
    logic [crc16_rx_pkg::APB_W-1:0]    pwdata;
    logic [crc16_rx_pkg::APB_W-1:0]    prdata;
    logic                              pready;

    t_frame_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int ready_hold;
    int frame_bytes;
    int bytes_in;
    int stall_cycles;

    crc16_modbus_frame_receiver_core DUT (.*);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.kind           = o_kind;
                got.data_byte      = o_data_byte;
                got.byte_index     = o_byte_index;
                got.status         = o_status;
                got.payload_length = o_payload_length;
                board.check_result(got);
            end
            if (i_in_valid && o_in_ready) begin
                board.note_byte(i_byte_in);
                bytes_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic reg_write(crc16_rx_pkg::t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= crc16_rx_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [7:0] h1, logic [7:0] h2, logic [7:0] key,
                             logic [15:0] max_len);
        reg_write(crc16_rx_pkg::REG_HDR_FIRST, {24'h0, h1});
        reg_write(crc16_rx_pkg::REG_HDR_SECOND, {24'h0, h2});
        reg_write(crc16_rx_pkg::REG_XOR_KEY, {24'h0, key});
        reg_write(crc16_rx_pkg::REG_MAX_LEN, {16'h0, max_len});
    endtask

    task automatic send_byte(logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_covered(logic [7:0] b, inout logic [15:0] crc);
        crc = modbus_crc_step(crc, b);
        send_byte(b);
        frame_bytes++;
    endtask

    task automatic send_frame(logic [15:0] len, bit bad_crc, int fill);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc16_rx_pkg::CRC_INIT;
        send_covered(board.hdr_first, crc);
        send_covered(board.hdr_second, crc);
        send_covered(len[7:0], crc);
        send_covered(len[15:8], crc);
        if (len == 16'h0000 || len > board.len_limit) return;
        for (int i = 0; i < int'(len); i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            send_covered(b, crc);
        end
        if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        frame_bytes += 2;
    endtask

    function automatic logic [15:0] pick_length();
        int roll;
        int cap;
        roll = $urandom_range(99);
        cap = (roll < 85) ? 12 : (roll < 97) ? 48 : 300;
        if (cap > int'(board.len_limit)) cap = int'(board.len_limit);
        return 16'($urandom_range(cap, 1));
    endfunction

    function automatic logic [15:0] bad_length();
        if (board.len_limit == 16'hFFFF || $urandom_range(3) == 0) return 16'h0000;
        return 16'($urandom_range(65535, int'(board.len_limit) + 1));
    endfunction

    task automatic send_random_item();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 60) begin
            send_frame(pick_length(), 1'b0, -1);
        end else if (pick < 72) begin
            send_frame(pick_length(), 1'b1, -1);
        end else if (pick < 80) begin
            send_frame(bad_length(), 1'b0, -1);
        end else if (pick < 87) begin
            send_byte(board.hdr_first);
            send_byte(8'($urandom));
            frame_bytes += 2;
        end else if (pick < 93) begin
            send_byte(board.hdr_first);
            frame_bytes++;
            send_frame(pick_length(), 1'($urandom_range(1)), -1);
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) send_byte(8'($urandom));
            frame_bytes += n;
        end
    endtask

    task automatic run_random(int target);
        frame_bytes = 0;
        while (frame_bytes < target) send_random_item();
    endtask

    // A byte that yields no result may still be in the pipeline when the
    // queue empties, so the task keeps waiting past that point before the block counts as idle.
    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        board       = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_byte_in   = 8'h00;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        send_idle_pct = 26;
        recv_idle_pct = 56;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(8'hA5, 8'h5A, 8'h3C, 16'd1024);
        send_frame(16'd1, 1'b0, 8'h00);
        send_frame(16'd0, 1'b0, -1);
        send_frame(16'hFFFF, 1'b0, -1);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_frame(16'd1, 1'b1, 8'hFF);
        run_random(200);
        finish_phase();

        configure(8'h00, 8'hFF, 8'hFF, 16'd1);
        run_random(200);
        finish_phase();

        send_idle_pct = 56;
        recv_idle_pct = 26;
        configure(8'hFF, 8'hFF, 8'h00, 16'd65529);
        run_random(200);
        finish_phase();

        configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(64, 2)));
        run_random(200);
        finish_phase();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(8'h7E, 8'h81, 8'hA5, 16'd20);
        ready_hold = 160;
        run_random(200);
        finish_phase();

        configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(300, 1)));
        run_random(200);
        finish_phase();

        $display("Accepted %0d input beats under six register settings and three idle mixes.",
                 bytes_in);
        $display("Checked %0d payload beats and frame ends: %0d good, %0d bad length, %0d bad CRC.",
                 board.payload_beats, board.ends_by_status[crc16_rx_pkg::ST_GOOD],
                 board.ends_by_status[crc16_rx_pkg::ST_BAD_LEN],
                 board.ends_by_status[crc16_rx_pkg::ST_BAD_CRC]);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/crc16_rx_pkg.sv
hw/rtl/crc16_modbus_frame_receiver_core.sv
test/tb_top.sv
